// ===== src/mcn_pkg.sv =====
// Package for the mesh centre-and-normalise block: sizes, codes and the types
// shared between the top level and its arithmetic unit. No dependencies.
`default_nettype none
package mcn_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 32;
   localparam int VERT_W       = 3 * COORD_W;
   localparam int SUM_W        = COORD_W + CNT_W;

   // Operand widths of the shared arithmetic unit.
   localparam int OPA_W        = 64;
   localparam int OPB_W        = 36;
   localparam int PROD_W       = 2 * OPB_W;
   localparam int STEP_W       = 7;
   localparam int MUL_STEPS    = OPB_W;
   localparam int DIV_STEPS    = OPA_W;

   // Root and square widths for the radius.
   localparam int SQ_W         = 68;
   localparam int SQX_W        = 72;
   localparam int ROOT_W       = SQX_W / 2;
   localparam int REM_W        = ROOT_W + 4;

   localparam logic [COORD_W-1:0] TARGET_RESET = 32'd65536;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic               start;
      arith_op_type       op;
      logic [OPA_W-1:0]   a;
      logic [OPB_W-1:0]   b;
   } arith_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [PROD_W-1:0]  result;
   } arith_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CENT_START,
      ST_CENT_WAIT,
      ST_RAD_READ,
      ST_RAD_MUL,
      ST_RAD_WAIT,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_EMIT_READ,
      ST_EMIT_MUL,
      ST_EMIT_MULW,
      ST_EMIT_DIVW,
      ST_EMIT_OUT
   } state_type;

endpackage
`default_nettype wire

// ===== src/mcn_req_if.sv =====
// Input channel of the mesh block: one vertex per transfer.
// Depends on mcn_pkg for the coordinate width.
`default_nettype none
interface mcn_req_if;
   import mcn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic                      final_vertex;

   modport source (output valid, pos_x, pos_y, pos_z, final_vertex, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, final_vertex, output ready);
endinterface
`default_nettype wire

// ===== src/mcn_rsp_if.sv =====
// Result channel of the mesh block: one normalised vertex per transfer.
// Depends on mcn_pkg for the coordinate width.
`default_nettype none
interface mcn_rsp_if;
   import mcn_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic signed [COORD_W-1:0] out_z;
   logic                      end_of_mesh;
   logic                      dropped;

   modport source (output valid, out_x, out_y, out_z, end_of_mesh, dropped, input ready);
   modport sink   (input valid, out_x, out_y, out_z, end_of_mesh, dropped, output ready);
endinterface
`default_nettype wire

// ===== src/mcn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module mcn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                         clock,
   input  wire logic                                         we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                             wdata,
   input  wire logic                                         re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== src/mcn_arith.sv =====
// Shared serial arithmetic unit: shift-add multiply and restoring divide,
// one bit a cycle through a single adder. Depends on mcn_pkg.
`default_nettype none
module mcn_arith
   import mcn_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire arith_req_type req,
   output arith_rsp_type      rsp
);
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [OPA_W-1:0]  opa_ff, opa_in;
   logic [OPB_W-1:0]  opb_ff, opb_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   arith_op_type      op_ff, op_in;

   logic [OPB_W+1:0]  add_x, add_y, add_s;
   logic              add_c;
   logic [STEP_W-1:0] last;

   // One adder serves both operations; divide adds the inverted divisor.
   always_comb begin
      if (op_ff == OP_MUL) begin
         add_x = {2'b00, acc_ff[PROD_W-1:OPB_W]};
         add_y = opb_ff[0] ? {2'b00, opa_ff[OPB_W-1:0]} : '0;
         add_c = 1'b0;
      end else begin
         add_x = {1'b0, acc_ff[OPB_W-1:0], opa_ff[OPA_W-1]};
         add_y = ~{2'b00, opb_ff};
         add_c = 1'b1;
      end
      add_s = add_x + add_y + {{(OPB_W+1){1'b0}}, add_c};
      last  = (op_ff == OP_MUL) ? STEP_W'(MUL_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
   end

   always_comb begin
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      if (req.start && !busy_ff) begin
         acc_in  = '0;
         opa_in  = req.a;
         opb_in  = req.b;
         op_in   = req.op;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            acc_in = {add_s[OPB_W:0], acc_ff[OPB_W-1:1]};
            opb_in = opb_ff >> 1;
         end else begin
            // Top bit of the sum is set when the trial subtraction borrows.
            if (add_s[OPB_W+1]) begin
               acc_in = {{(PROD_W-OPB_W-1){1'b0}}, add_x[OPB_W:0]};
            end else begin
               acc_in = {{(PROD_W-OPB_W-1){1'b0}}, add_s[OPB_W:0]};
            end
            opa_in = {opa_ff[OPA_W-2:0], ~add_s[OPB_W+1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
   end

   assign rsp.busy   = busy_ff;
   assign rsp.done   = done_ff;
   assign rsp.result = (op_ff == OP_MUL) ? acc_ff : {{(PROD_W-OPA_W){1'b0}}, opa_ff};
endmodule
`default_nettype wire

// ===== src/mesh_center_and_normalize.sv =====
// Top level of the mesh centre-and-normalise block: store, sequencer, root
// and output stage. Depends on mcn_pkg, mcn_req_if, mcn_rsp_if, mcn_ram, mcn_arith.
//
//   Channel | Direction | Transfer carries
//   --------+-----------+---------------------------------------------------
//   req     | in        | pos_x, pos_y, pos_z, final_vertex
//   rsp     | out       | out_x, out_y, out_z, end_of_mesh, dropped
//   csr     | in        | target_size (write enable and data)
//
// A non-final vertex is summed and stored while the store has room. The final
// vertex starts the work, all on the one serial multiply/divide unit: three
// centroid divisions; per stored vertex a read and three squares; one root;
// then per vertex a read, three multiply and divide pairs (none when the radius
// is zero) and an output state. Reset is synchronous and clears the sums, the
// count and the sequencer; the vertex store needs no clearing. A stalled result
// simply holds the sequencer.
`default_nettype none
module mesh_center_and_normalize
   import mcn_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   mcn_req_if.sink                   req_chan,
   mcn_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_wr_en,
   input  wire logic [COORD_W-1:0]   csr_wr_data
);
   state_type state_ff, state_in;

   logic [COORD_W-1:0]       target_ff;
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic [CNT_W-1:0]         count_ff;
   logic                     ovf_ff;
   logic [CNT_W-1:0]         idx_ff;
   logic [1:0]               axis_ff;
   logic signed [COORD_W:0]  cent_ff [3];
   logic [SQ_W-1:0]          sq_acc_ff;
   logic [SQ_W-1:0]          sq_max_ff;
   logic [SQX_W-1:0]         sqx_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [STEP_W-1:0]        sq_cnt_ff;
   logic [COORD_W-1:0]       out_ff [3];

   // Control outputs of the sequencer.
   logic                     req_ready;
   logic                     ram_re;
   logic                     rsp_valid;
   arith_req_type            ar_req;
   arith_rsp_type            ar_rsp;

   logic                     accept;
   logic                     store_ok;
   logic [VERT_W-1:0]        ram_rdata;
   logic                     last_vertex;

   // The current coordinate against its centroid component.
   logic signed [COORD_W:0]  cur_v;
   logic signed [COORD_W+1:0] diff;
   logic [COORD_W:0]         diff_mag;
   logic signed [SUM_W-1:0]  cur_sum;
   logic [SUM_W-1:0]         sum_mag;
   logic [SQ_W-1:0]          sq_sum;
   logic                     radius_zero;

   // Root step: bring down two bits and try the next root bit.
   logic [REM_W-1:0]         sq_rem2;
   logic [REM_W-1:0]         sq_trial;

   assign accept      = req_chan.valid && req_ready;
   assign store_ok    = count_ff < CNT_W'(MAX_VERTICES);
   assign last_vertex = (idx_ff + 1'b1) == count_ff;
   assign radius_zero = root_ff == '0;

   always_comb begin
      case (axis_ff)
         2'd0:    cur_v = {ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]};
         2'd1:    cur_v = {ram_rdata[2*COORD_W-1], ram_rdata[2*COORD_W-1:COORD_W]};
         default: cur_v = {ram_rdata[3*COORD_W-1], ram_rdata[3*COORD_W-1:2*COORD_W]};
      endcase
      case (axis_ff)
         2'd0:    cur_sum = sum_ff[0];
         2'd1:    cur_sum = sum_ff[1];
         default: cur_sum = sum_ff[2];
      endcase
      diff     = {cur_v[COORD_W], cur_v} - {cent_ff[axis_ff][COORD_W], cent_ff[axis_ff]};
      diff_mag = diff[COORD_W+1] ? (COORD_W+1)'(-diff) : diff[COORD_W:0];
      sum_mag  = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
      sq_sum   = sq_acc_ff + ar_rsp.result[SQ_W-1:0];
      sq_rem2  = {rem_ff[REM_W-3:0], sqx_ff[SQX_W-1:SQX_W-2]};
      sq_trial = {{(REM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   end

   // Truncated quotient, signed by the difference and clamped to 32 bits.
   function automatic logic [COORD_W-1:0] saturate(input logic neg,
                                                   input logic [OPA_W-1:0] q);
      logic [OPA_W-1:0] lim;
      lim = neg ? OPA_W'(64'h8000_0000) : OPA_W'(64'h7FFF_FFFF);
      if (q > lim) begin
         saturate = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         saturate = neg ? COORD_W'(-q) : q[COORD_W-1:0];
      end
   endfunction

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_chan.final_vertex) begin
               state_in = ST_CENT_START;
            end
         end
         ST_CENT_START: state_in = ST_CENT_WAIT;
         ST_CENT_WAIT: begin
            if (ar_rsp.done) begin
               state_in = (axis_ff == 2'd2) ? ST_RAD_READ : ST_CENT_START;
            end
         end
         ST_RAD_READ: state_in = ST_RAD_MUL;
         ST_RAD_MUL:  state_in = ST_RAD_WAIT;
         ST_RAD_WAIT: begin
            if (ar_rsp.done) begin
               if (axis_ff != 2'd2) begin
                  state_in = ST_RAD_MUL;
               end else begin
                  state_in = last_vertex ? ST_SQRT_INIT : ST_RAD_READ;
               end
            end
         end
         ST_SQRT_INIT: state_in = ST_SQRT;
         ST_SQRT: begin
            if (sq_cnt_ff == STEP_W'(ROOT_W - 1)) begin
               state_in = ST_EMIT_READ;
            end
         end
         ST_EMIT_READ: state_in = ST_EMIT_MUL;
         ST_EMIT_MUL: begin
            if (radius_zero) begin
               state_in = (axis_ff == 2'd2) ? ST_EMIT_OUT : ST_EMIT_MUL;
            end else begin
               state_in = ST_EMIT_MULW;
            end
         end
         ST_EMIT_MULW: begin
            if (ar_rsp.done) begin
               state_in = ST_EMIT_DIVW;
            end
         end
         ST_EMIT_DIVW: begin
            if (ar_rsp.done) begin
               state_in = (axis_ff == 2'd2) ? ST_EMIT_OUT : ST_EMIT_MUL;
            end
         end
         ST_EMIT_OUT: begin
            if (rsp_chan.ready) begin
               state_in = last_vertex ? ST_IDLE : ST_EMIT_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready  = 1'b0;
      ram_re     = 1'b0;
      rsp_valid  = 1'b0;
      ar_req     = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_CENT_START: begin
            ar_req.start = 1'b1;
            ar_req.op    = OP_DIV;
            ar_req.a     = {{(OPA_W-SUM_W){1'b0}}, sum_mag};
            ar_req.b     = {{(OPB_W-CNT_W){1'b0}}, count_ff};
         end
         ST_RAD_READ, ST_EMIT_READ: ram_re = 1'b1;
         ST_RAD_MUL: begin
            ar_req.start = 1'b1;
            ar_req.a     = {{(OPA_W-COORD_W-1){1'b0}}, diff_mag};
            ar_req.b     = {{(OPB_W-COORD_W-1){1'b0}}, diff_mag};
         end
         ST_EMIT_MUL: begin
            ar_req.start = !radius_zero;
            ar_req.a     = {{(OPA_W-COORD_W-1){1'b0}}, diff_mag};
            ar_req.b     = {{(OPB_W-COORD_W){1'b0}}, target_ff};
         end
         ST_EMIT_MULW: begin
            ar_req.start = ar_rsp.done;
            ar_req.op    = OP_DIV;
            ar_req.a     = ar_rsp.result[OPA_W-1:0];
            ar_req.b     = root_ff;
         end
         ST_EMIT_OUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         target_ff <= TARGET_RESET;
         sum_ff    <= '{default: '0};
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         if (accept) begin
            if (store_ok) begin
               sum_ff[0] <= sum_ff[0] + SUM_W'(req_chan.pos_x);
               sum_ff[1] <= sum_ff[1] + SUM_W'(req_chan.pos_y);
               sum_ff[2] <= sum_ff[2] + SUM_W'(req_chan.pos_z);
               count_ff  <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
            end
         end
         if (state_ff == ST_EMIT_OUT && rsp_chan.ready && last_vertex) begin
            sum_ff   <= '{default: '0};
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
      end

      // Working registers of the sequencer carry no reset.
      case (state_ff)
         ST_IDLE: begin
            axis_ff   <= 2'd0;
            idx_ff    <= '0;
            sq_acc_ff <= '0;
            sq_max_ff <= '0;
         end
         ST_CENT_WAIT: begin
            if (ar_rsp.done) begin
               cent_ff[axis_ff] <= cur_sum[SUM_W-1] ? (COORD_W+1)'(-ar_rsp.result[COORD_W:0])
                                                    : ar_rsp.result[COORD_W:0];
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            end
         end
         ST_RAD_WAIT: begin
            if (ar_rsp.done) begin
               if (axis_ff == 2'd2) begin
                  axis_ff   <= 2'd0;
                  sq_acc_ff <= '0;
                  idx_ff    <= last_vertex ? '0 : idx_ff + 1'b1;
                  if (sq_sum > sq_max_ff) begin
                     sq_max_ff <= sq_sum;
                  end
               end else begin
                  axis_ff   <= axis_ff + 2'd1;
                  sq_acc_ff <= sq_sum;
               end
            end
         end
         ST_SQRT_INIT: begin
            sqx_ff    <= {{(SQX_W-SQ_W){1'b0}}, sq_max_ff};
            rem_ff    <= '0;
            root_ff   <= '0;
            sq_cnt_ff <= '0;
         end
         ST_SQRT: begin
            sqx_ff    <= sqx_ff << 2;
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
            if (sq_rem2 >= sq_trial) begin
               rem_ff  <= sq_rem2 - sq_trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= sq_rem2;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         ST_EMIT_READ: axis_ff <= 2'd0;
         ST_EMIT_MUL: begin
            if (radius_zero) begin
               out_ff[axis_ff] <= '0;
               axis_ff         <= axis_ff + 2'd1;
            end
         end
         ST_EMIT_DIVW: begin
            if (ar_rsp.done) begin
               out_ff[axis_ff] <= saturate(diff[COORD_W+1], ar_rsp.result[OPA_W-1:0]);
               axis_ff         <= axis_ff + 2'd1;
            end
         end
         ST_EMIT_OUT: begin
            if (rsp_chan.ready) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   mcn_ram #(
      .WIDTH (VERT_W),
      .DEPTH (MAX_VERTICES)
   ) u_store (
      .clock (clock),
      .we    (accept && store_ok),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata ({req_chan.pos_z, req_chan.pos_y, req_chan.pos_x}),
      .re    (ram_re),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   mcn_arith u_arith (
      .clock (clock),
      .reset (reset),
      .req   (ar_req),
      .rsp   (ar_rsp)
   );

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.out_x       = out_ff[0];
   assign rsp_chan.out_y       = out_ff[1];
   assign rsp_chan.out_z       = out_ff[2];
   assign rsp_chan.end_of_mesh = last_vertex;
   assign rsp_chan.dropped     = ovf_ff;
endmodule
`default_nettype wire
